[design/i2cm_pkg.sv]
// Package for the I2C master bit sequencer: item types, phase codes and
// sequencer state. No dependencies; every other file imports it.
`default_nettype none

package i2cm_pkg;

    // Largest byte count a transaction may carry; larger requests are capped.
    localparam int MAX_BYTES = 16;
    localparam int BL_W      = $clog2(MAX_BYTES + 1);

    // Bit of the shift register that goes out first on SDA.
    localparam logic [7:0] MSB_MASK = 8'h80;

    // Bus phases, one-hot.
    typedef enum logic [21:0] {
        PH_IDLE    = 22'h000001,
        PH_INIT    = 22'h000002,
        PH_ST_SDA  = 22'h000004,
        PH_ST_SCL  = 22'h000008,
        PH_TX_SET  = 22'h000010,
        PH_TX_RISE = 22'h000020,
        PH_TX_HIGH = 22'h000040,
        PH_TX_FALL = 22'h000080,
        PH_AK_SET  = 22'h000100,
        PH_AK_RISE = 22'h000200,
        PH_AK_HIGH = 22'h000400,
        PH_AK_FALL = 22'h000800,
        PH_RX_RISE = 22'h001000,
        PH_RX_HIGH = 22'h002000,
        PH_RX_FALL = 22'h004000,
        PH_MA_SET  = 22'h008000,
        PH_MA_RISE = 22'h010000,
        PH_MA_HIGH = 22'h020000,
        PH_MA_FALL = 22'h040000,
        PH_SP_SDA  = 22'h080000,
        PH_SP_RISE = 22'h100000,
        PH_SP_HIGH = 22'h200000
    } t_phase;

    // One timing tick with sampled wire levels.
    typedef struct packed {
        logic       go;
        logic       opcode;
        logic [7:0] addr_byte;
        logic [4:0] byte_count;
        logic [7:0] phase_ticks;
        logic [7:0] write_byte;
        logic       scl_line;
        logic       sda_line;
    } t_in_item;

    // Result of one tick.
    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       byte_taken;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        logic       nacked;
        logic       busy_res;
    } t_out_item;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        t_phase            phase;
        logic [7:0]        wait_count;
        logic [2:0]        bit_index;
        logic [BL_W-1:0]   bytes_left;
        logic [7:0]        shift_reg;
        logic              read_mode;
        logic [7:0]        phase_len;
        logic              nack_seen;
        logic              scl_low_reg;
        logic              sda_low_reg;
    } t_state;

endpackage

`default_nettype wire

[design/i2cm_ifs.sv]
// Valid/ready channel interfaces for the I2C master bit sequencer.
// Depends on i2cm_pkg for the payload types.
`default_nettype none

interface i2cm_in_if;
    import i2cm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/i2cm_step.sv]
// Next-state and result logic for one timing tick of the I2C sequencer.
// Depends on i2cm_pkg; purely combinational, registered by the top level.
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
(
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    output t_state         o_state,
    output t_out_item      o_res
);

    t_state          n;
    t_phase          nxt;
    logic            enter;
    logic            rise;
    logic            taken;
    logic            rvalid;
    logic            done;
    logic            nk;
    logic [7:0]      rdata;
    logic [BL_W-1:0] cap_count;
    logic [2:0]      bit_inc;

    // Cap the requested byte count.
    always_comb begin
        if (32'(i_item.byte_count) > MAX_BYTES) begin
            cap_count = BL_W'(MAX_BYTES);
        end else begin
            cap_count = BL_W'(i_item.byte_count);
        end
    end

    assign bit_inc = i_state.bit_index + 3'd1;

    // SCL-released phases that wait for the wire to read high.
    assign rise = (i_state.phase == PH_TX_RISE) || (i_state.phase == PH_AK_RISE) ||
                  (i_state.phase == PH_RX_RISE) || (i_state.phase == PH_MA_RISE) ||
                  (i_state.phase == PH_SP_RISE);

    // Advance the phase sequencer.
    always_comb begin
        n      = i_state;
        nxt    = PH_IDLE;
        enter  = 1'b0;
        taken  = 1'b0;
        rvalid = 1'b0;
        done   = 1'b0;
        nk     = 1'b0;
        rdata  = 8'd0;
        if (i_state.phase == PH_IDLE) begin
            if (i_item.go) begin
                n.read_mode  = i_item.opcode;
                n.shift_reg  = i_item.addr_byte;
                n.bytes_left = cap_count;
                n.phase_len  = i_item.phase_ticks;
                n.bit_index  = 3'd0;
                n.nack_seen  = 1'b0;
                enter        = 1'b1;
                nxt          = PH_INIT;
            end
        end else if ({1'b0, i_state.wait_count} + 9'd1 < {1'b0, i_state.phase_len}) begin
            n.wait_count = i_state.wait_count + 8'd1;
        end else if (!rise || i_item.scl_line) begin
            enter = 1'b1;
            unique case (i_state.phase)
                PH_INIT:    nxt = PH_ST_SDA;
                PH_ST_SDA:  nxt = PH_ST_SCL;
                PH_ST_SCL: begin
                    n.bit_index = 3'd0;
                    nxt         = PH_TX_SET;
                end
                PH_TX_SET:  nxt = PH_TX_RISE;
                PH_TX_RISE: nxt = PH_TX_HIGH;
                PH_TX_HIGH: nxt = PH_TX_FALL;
                PH_TX_FALL: begin
                    n.shift_reg = {i_state.shift_reg[6:0], 1'b0};
                    n.bit_index = bit_inc;
                    nxt         = (bit_inc == 3'd0) ? PH_AK_SET : PH_TX_SET;
                end
                PH_AK_SET:  nxt = PH_AK_RISE;
                PH_AK_RISE: nxt = PH_AK_HIGH;
                PH_AK_HIGH: begin
                    if (i_item.sda_line) begin
                        n.nack_seen = 1'b1;
                    end
                    nxt = PH_AK_FALL;
                end
                PH_AK_FALL: begin
                    if (i_state.nack_seen || i_state.bytes_left == '0) begin
                        nxt = PH_SP_SDA;
                    end else if (i_state.read_mode) begin
                        n.bit_index = 3'd0;
                        nxt         = PH_RX_RISE;
                    end else begin
                        n.shift_reg  = i_item.write_byte;
                        taken        = 1'b1;
                        n.bytes_left = i_state.bytes_left - BL_W'(1);
                        n.bit_index  = 3'd0;
                        nxt          = PH_TX_SET;
                    end
                end
                PH_RX_RISE: nxt = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    n.shift_reg = {i_state.shift_reg[6:0], i_item.sda_line};
                    nxt         = PH_RX_FALL;
                end
                PH_RX_FALL: begin
                    n.bit_index = bit_inc;
                    if (bit_inc == 3'd0) begin
                        rdata        = i_state.shift_reg;
                        rvalid       = 1'b1;
                        n.bytes_left = i_state.bytes_left - BL_W'(1);
                        nxt          = PH_MA_SET;
                    end else begin
                        nxt = PH_RX_RISE;
                    end
                end
                PH_MA_SET:  nxt = PH_MA_RISE;
                PH_MA_RISE: nxt = PH_MA_HIGH;
                PH_MA_HIGH: nxt = PH_MA_FALL;
                PH_MA_FALL: begin
                    if (i_state.bytes_left != '0) begin
                        n.bit_index = 3'd0;
                        nxt         = PH_RX_RISE;
                    end else begin
                        nxt = PH_SP_SDA;
                    end
                end
                PH_SP_SDA:  nxt = PH_SP_RISE;
                PH_SP_RISE: nxt = PH_SP_HIGH;
                PH_SP_HIGH: begin
                    done = 1'b1;
                    nk   = i_state.nack_seen;
                    nxt  = PH_IDLE;
                end
                default:    nxt = PH_IDLE;
            endcase
        end

        // Apply the line drives of the phase being entered.
        if (enter) begin
            n.phase      = nxt;
            n.wait_count = 8'd0;
            unique case (nxt) inside
                PH_IDLE, PH_INIT: begin
                    n.scl_low_reg = 1'b0;
                    n.sda_low_reg = 1'b0;
                end
                PH_ST_SDA, PH_SP_SDA: n.sda_low_reg = 1'b1;
                PH_ST_SCL, PH_TX_FALL, PH_AK_FALL, PH_RX_FALL, PH_MA_FALL:
                    n.scl_low_reg = 1'b1;
                PH_TX_SET:  n.sda_low_reg = ((n.shift_reg & MSB_MASK) == 8'd0);
                PH_TX_RISE, PH_AK_RISE, PH_MA_RISE, PH_SP_RISE:
                    n.scl_low_reg = 1'b0;
                PH_AK_SET:  n.sda_low_reg = 1'b0;
                PH_RX_RISE: begin
                    n.sda_low_reg = 1'b0;
                    n.scl_low_reg = 1'b0;
                end
                PH_MA_SET:  n.sda_low_reg = (n.bytes_left != '0);
                default: ;
            endcase
        end
    end

    // Form the result beat from the updated state.
    always_comb begin
        o_state             = n;
        o_res.scl_drive_low = n.scl_low_reg;
        o_res.sda_drive_low = n.sda_low_reg;
        o_res.byte_taken    = taken;
        o_res.read_data     = rdata;
        o_res.read_valid    = rvalid;
        o_res.done_res      = done;
        o_res.nacked        = nk;
        o_res.busy_res      = (n.phase != PH_IDLE);
    end

endmodule

`default_nettype wire

[design/i2c_master_bit_sequencer_core.sv]
// Top level of the I2C master bit sequencer: state register, step logic
// and output register. Depends on i2cm_pkg, i2cm_ifs and i2cm_step.
//
//   channel   dir   beat contents
//   i_in      in    one timing tick: start request, transfer setup, wire levels
//   o_out     out   one result per tick: line drives, byte and status flags
//
// A new beat is accepted every cycle while the output register is empty or
// being drained. The sequencer state and the result register are the only
// storage; one pass of step logic sits between.
// Reset idles the sequencer with both lines released and empties the output.
// A stall on o_out holds the result and stops input until it is taken.
`default_nettype none

module i2c_master_bit_sequencer_core
    import i2cm_pkg::*;
(
    input wire          i_clk,
    input wire          i_rst_n,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_out
);

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_ready;
    logic      accept;

    // Take a beat when the output register frees up this cycle.
    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    i2cm_step u_step (
        .i_state (r_state),
        .i_item  (i_in.data),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Hold sequencer state; advance on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_IDLE;
            r_state.wait_count  <= 8'd0;
            r_state.bit_index   <= 3'd0;
            r_state.bytes_left  <= '0;
            r_state.shift_reg   <= 8'd0;
            r_state.read_mode   <= 1'b0;
            r_state.phase_len   <= 8'd0;
            r_state.nack_seen   <= 1'b0;
            r_state.scl_low_reg <= 1'b0;
            r_state.sda_low_reg <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output valid: set on accept, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

[test/i2cm_checker.sv]
// Scoreboard for the I2C master bit sequencer: tracks the tick and result channels,
// predicts every result beat from the accepted ticks and compares field by field.
// Depends on i2cm_pkg and i2cm_ifs.
`default_nettype none

module i2cm_checker
    import i2cm_pkg::*;
(
    input wire   i_clk,
    input wire   i_rst_n,
    i2cm_in_if   i_tick,
    i2cm_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_PRINTS = 100;

    // Predicted sequencer state
    t_phase          ph;
    logic [7:0]      wait_cnt;
    logic [2:0]      bit_idx;
    logic [BL_W-1:0] bytes_rem;
    logic [7:0]      shreg;
    logic            rd_mode;
    logic [7:0]      ph_len;
    logic            nack_flag;
    logic            scl_low;
    logic            sda_low;

    t_out_item expected_res_q[$];
    t_out_item want;
    int        err_cnt;
    int        beat_no;

    // Clear the predicted state to its post-reset values
    function automatic void clear_bus_state();
        ph        = PH_IDLE;
        wait_cnt  = '0;
        bit_idx   = '0;
        bytes_rem = '0;
        shreg     = '0;
        rd_mode   = 1'b0;
        ph_len    = '0;
        nack_flag = 1'b0;
        scl_low   = 1'b0;
        sda_low   = 1'b0;
    endfunction

    // Move to a new phase and apply the line drives that take effect on entry
    function automatic void enter_phase(t_phase p);
        ph       = p;
        wait_cnt = '0;
        case (p)
            PH_IDLE, PH_INIT: begin
                scl_low = 1'b0;
                sda_low = 1'b0;
            end
            PH_ST_SDA, PH_SP_SDA: sda_low = 1'b1;
            PH_ST_SCL, PH_TX_FALL, PH_AK_FALL, PH_RX_FALL, PH_MA_FALL: scl_low = 1'b1;
            PH_TX_SET:  sda_low = ((shreg & MSB_MASK) == 8'h00);
            PH_TX_RISE, PH_AK_RISE, PH_MA_RISE, PH_SP_RISE: scl_low = 1'b0;
            PH_AK_SET:  sda_low = 1'b0;
            PH_RX_RISE: begin
                sda_low = 1'b0;
                scl_low = 1'b0;
            end
            PH_MA_SET:  sda_low = (bytes_rem != 0);
            default: ;
        endcase
    endfunction

    // Advance the bus sequencer by one tick and return the result it produces
    function automatic t_out_item bus_step(input t_in_item t);
        t_out_item r;
        logic      rising;
        r = '0;
        if (ph == PH_IDLE) begin
            if (t.go) begin
                rd_mode   = t.opcode;
                shreg     = t.addr_byte;
                bytes_rem = (t.byte_count > MAX_BYTES) ? BL_W'(MAX_BYTES) : t.byte_count;
                ph_len    = t.phase_ticks;
                bit_idx   = '0;
                nack_flag = 1'b0;
                enter_phase(PH_INIT);
            end
        end else if (int'(wait_cnt) + 1 < int'(ph_len)) begin
            wait_cnt = wait_cnt + 8'd1;
        end else begin
            // SCL high phases hold until the wire actually reads high
            rising = (ph inside {PH_TX_RISE, PH_AK_RISE, PH_RX_RISE, PH_MA_RISE, PH_SP_RISE});
            if (!rising || t.scl_line) begin
                case (ph)
                    PH_INIT:    enter_phase(PH_ST_SDA);
                    PH_ST_SDA:  enter_phase(PH_ST_SCL);
                    PH_ST_SCL: begin
                        bit_idx = '0;
                        enter_phase(PH_TX_SET);
                    end
                    PH_TX_SET:  enter_phase(PH_TX_RISE);
                    PH_TX_RISE: enter_phase(PH_TX_HIGH);
                    PH_TX_HIGH: enter_phase(PH_TX_FALL);
                    PH_TX_FALL: begin
                        shreg   = shreg << 1;
                        bit_idx = bit_idx + 3'd1;
                        enter_phase((bit_idx == 0) ? PH_AK_SET : PH_TX_SET);
                    end
                    PH_AK_SET:  enter_phase(PH_AK_RISE);
                    PH_AK_RISE: enter_phase(PH_AK_HIGH);
                    PH_AK_HIGH: begin
                        if (t.sda_line) nack_flag = 1'b1;
                        enter_phase(PH_AK_FALL);
                    end
                    PH_AK_FALL: begin
                        if (nack_flag || bytes_rem == 0) begin
                            enter_phase(PH_SP_SDA);
                        end else if (rd_mode) begin
                            bit_idx = '0;
                            enter_phase(PH_RX_RISE);
                        end else begin
                            shreg        = t.write_byte;
                            r.byte_taken = 1'b1;
                            bytes_rem    = bytes_rem - 1'b1;
                            bit_idx      = '0;
                            enter_phase(PH_TX_SET);
                        end
                    end
                    PH_RX_RISE: enter_phase(PH_RX_HIGH);
                    PH_RX_HIGH: begin
                        shreg = {shreg[6:0], t.sda_line};
                        enter_phase(PH_RX_FALL);
                    end
                    PH_RX_FALL: begin
                        bit_idx = bit_idx + 3'd1;
                        if (bit_idx == 0) begin
                            r.read_data  = shreg;
                            r.read_valid = 1'b1;
                            bytes_rem    = bytes_rem - 1'b1;
                            enter_phase(PH_MA_SET);
                        end else begin
                            enter_phase(PH_RX_RISE);
                        end
                    end
                    PH_MA_SET:  enter_phase(PH_MA_RISE);
                    PH_MA_RISE: enter_phase(PH_MA_HIGH);
                    PH_MA_HIGH: enter_phase(PH_MA_FALL);
                    PH_MA_FALL: begin
                        if (bytes_rem != 0) begin
                            bit_idx = '0;
                            enter_phase(PH_RX_RISE);
                        end else begin
                            enter_phase(PH_SP_SDA);
                        end
                    end
                    PH_SP_SDA:  enter_phase(PH_SP_RISE);
                    PH_SP_RISE: enter_phase(PH_SP_HIGH);
                    PH_SP_HIGH: begin
                        r.done_res = 1'b1;
                        r.nacked   = nack_flag;
                        enter_phase(PH_IDLE);
                    end
                    default:    enter_phase(PH_IDLE);
                endcase
            end
        end
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.busy_res      = (ph != PH_IDLE);
        return r;
    endfunction

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(input string what);
        if (err_cnt < MAX_PRINTS) $display("[%0t] result beat %0d: %s", $time, beat_no, what);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, exp_val));
    endtask

    // Single-bit flags compare at their own width
    task automatic check_bit(input string name, input logic got, input logic exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %0b, predicted %0b", name, got, exp_val));
    endtask

    // Compare result beats first, then predict from the tick accepted on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_bus_state();
            expected_res_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_res_q.size() == 0) begin
                    report_mismatch("result beat with no tick waiting");
                end else begin
                    want = expected_res_q.pop_front();
                    check_bit("scl_drive_low", i_res.data.scl_drive_low, want.scl_drive_low);
                    check_bit("sda_drive_low", i_res.data.sda_drive_low, want.sda_drive_low);
                    check_bit("byte_taken",    i_res.data.byte_taken,    want.byte_taken);
                    check_field("read_data",   i_res.data.read_data,     want.read_data);
                    check_bit("read_valid",    i_res.data.read_valid,    want.read_valid);
                    check_bit("done_res",      i_res.data.done_res,      want.done_res);
                    check_bit("nacked",        i_res.data.nacked,        want.nacked);
                    check_bit("busy_res",      i_res.data.busy_res,      want.busy_res);
                end
                beat_no++;
            end
            if (i_tick.valid && i_tick.ready)
                expected_res_q.push_back(bus_step(i_tick.data));
        end
        o_pending    <= expected_res_q.size();
        o_fail_count <= err_cnt;
    end

endmodule

`default_nettype wire

[test/tb.sv]
// Top of the I2C master bit sequencer testbench: clock, reset, tick stimulus
// with slave-side wire levels, result backpressure and the verdict.
// Depends on i2cm_pkg, i2cm_ifs, i2cm_checker and the sequencer core.
`default_nettype none

module tb;
    import i2cm_pkg::*;

    // How the slave answers on SDA during a directed transfer
    typedef enum int {
        SDA_HELD_LOW,
        SDA_HELD_HIGH,
        SDA_RANDOM
    } t_sda_mode;

    localparam int RANDOM_TICKS = 300;
    localparam int END_SETTLE   = 8;
    localparam int RUN_LIMIT    = 10_000_000;

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   sda_one_pct;
    int   scl_hold;
    int   stops_seen;
    int   fail_count;
    int   pending;

    i2cm_in_if  tick_ch ();
    i2cm_out_if res_ch ();

    i2c_master_bit_sequencer_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch)
    );

    i2cm_checker i_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Count completed STOPs so directed transfers know when to move on
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready && res_ch.data.done_res)
            stops_seen <= stops_seen + 1;
    end

    // One tick with random content; go ticks carry mostly short transfers
    function automatic t_in_item rand_tick();
        t_in_item t;
        int       k;
        t.go         = ($urandom_range(99) < 6);
        t.opcode     = 1'($urandom_range(1));
        t.addr_byte  = 8'($urandom_range(255));
        t.write_byte = 8'($urandom_range(255));
        if (t.go) begin
            k = $urandom_range(99);
            if (k < 60) begin
                t.byte_count  = 5'($urandom_range(3));
                t.phase_ticks = 8'($urandom_range(3));
            end else if (k < 85) begin
                t.byte_count  = 5'($urandom_range(16, 4));
                t.phase_ticks = 8'($urandom_range(1));
            end else if (k < 95) begin
                t.byte_count  = 5'($urandom_range(31, 17));
                t.phase_ticks = 8'd0;
            end else begin
                t.byte_count  = 5'd0;
                t.phase_ticks = 8'($urandom_range(12, 4));
            end
        end else begin
            t.byte_count  = 5'($urandom_range(31));
            t.phase_ticks = 8'($urandom_range(255));
        end
        // Slave holds SCL low in bursts, with the odd single low sample
        if (scl_hold > 0) begin
            scl_hold--;
            t.scl_line = 1'b0;
        end else if ($urandom_range(99) < 3) begin
            scl_hold   = $urandom_range(12);
            t.scl_line = 1'b0;
        end else begin
            t.scl_line = ($urandom_range(99) >= 8);
        end
        t.sda_line = ($urandom_range(99) < sda_one_pct);
        return t;
    endfunction

    // Offer one tick, with random sender gaps, and hold it until accepted
    task automatic send_tick(input t_in_item t);
        while ($urandom_range(99) < gap_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    // Start one transfer and feed ticks until its STOP has come out
    task automatic run_transfer(input logic op, input logic [7:0] addr, input logic [4:0] cnt,
                                input logic [7:0] plen, input t_sda_mode sda_mode,
                                input bit go_while_busy);
        t_in_item t;
        int       start_stops;
        int       n;
        start_stops = stops_seen;
        t = rand_tick();
        t.go          = 1'b1;
        t.opcode      = op;
        t.addr_byte   = addr;
        t.byte_count  = cnt;
        t.phase_ticks = plen;
        t.scl_line    = 1'b1;
        send_tick(t);
        n = 0;
        while (stops_seen == start_stops) begin
            t = rand_tick();
            t.go = go_while_busy && (n < 20);
            if (sda_mode != SDA_RANDOM) begin
                t.scl_line = 1'b1;
                t.sda_line = (sda_mode == SDA_HELD_HIGH);
            end
            send_tick(t);
            n++;
        end
    endtask

    initial begin
        int i;
        rst_n         <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        gap_pct     = 0;
        stall_pct   = 0;
        sda_one_pct = 30;
        scl_hold    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed transfers: empty ones, short reads and writes, address NACK,
        // capped count, longer phase timing, stretching and go while busy
        run_transfer(1'b0, 8'h00, 5'd0,  8'd0, SDA_HELD_LOW,  1'b0);
        run_transfer(1'b1, 8'hA1, 5'd0,  8'd1, SDA_HELD_LOW,  1'b0);
        run_transfer(1'b0, 8'h5A, 5'd2,  8'd1, SDA_HELD_LOW,  1'b1);
        run_transfer(1'b1, 8'h81, 5'd2,  8'd0, SDA_HELD_LOW,  1'b0);
        run_transfer(1'b1, 8'h7F, 5'd1,  8'd2, SDA_HELD_HIGH, 1'b0);
        run_transfer(1'b1, 8'h3C, 5'd31, 8'd0, SDA_HELD_LOW,  1'b0);
        run_transfer(1'b1, 8'hC3, 5'd1,  8'd1, SDA_RANDOM,    1'b0);
        run_transfer(1'b0, 8'h96, 5'd1,  8'd1, SDA_RANDOM,    1'b0);
        run_transfer(1'b0, 8'hFF, 5'd0,  8'd3, SDA_HELD_LOW,  1'b0);

        // Random ticks across the gap and stall phases
        for (i = 0; i < RANDOM_TICKS; i++) begin
            case ((i * 4) / RANDOM_TICKS)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 50;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 50;
                end
                default: begin
                    gap_pct   = 10;
                    stall_pct = 10;
                end
            endcase
            // Alternate between mostly-ACK stretches and NACK-heavy ones
            if (i % 150 == 0) sda_one_pct = (sda_one_pct == 10) ? 40 : 10;
            send_tick(rand_tick());
        end
        tick_ch.valid <= 1'b0;

        // Drain outstanding results, then settle
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0) begin
            $display("i2c_master_bit_sequencer_core test passed");
        end else begin
            $display("i2c_master_bit_sequencer_core test failed");
        end
        $finish;
    end

    // Watchdog on the whole run
    initial begin
        #(RUN_LIMIT);
        $display("i2c_master_bit_sequencer_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
